// File: rtl/core/sitoa_pkg.sv
package sitoa_pkg;
  localparam int VALUE_BITS = 64;
  localparam int DIGITS = 20;
  localparam int DCNT_W = 5;
  localparam int CHAR_W = 8;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [63:0] VALUE_MASK = {64{1'b1}} >> (64 - VALUE_BITS);

  typedef logic [3:0] digit_t;
  typedef digit_t [DIGITS-1:0] digit_vec_t;
endpackage

// File: rtl/core/sitoa_if.sv
interface sitoa_in_if;
  logic valid;
  logic ready;
  logic signed [63:0] value;
  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface sitoa_out_if;
  logic valid;
  logic ready;
  logic [7:0] char_out;
  logic last;
  modport source (output valid, output char_out, output last, input ready);
  modport sink (input valid, input char_out, input last, output ready);
endinterface

// File: rtl/core/sitoa_digit_stage.sv
// One digit step: two register stages peel off one decimal digit of the magnitude.
module sitoa_digit_stage (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic vld_in,
  input  logic [63:0] mag_in,
  input  logic neg_in,
  input  sitoa_pkg::digit_vec_t dig_in,
  input  logic [4:0] idx,
  output logic vld_r,
  output logic [63:0] mag_r,
  output logic neg_r,
  output sitoa_pkg::digit_vec_t dig_r
);
  import sitoa_pkg::*;
  logic        vld_a_r;
  logic [63:0] mag_a_r;
  logic [63:0] qa_r, qa_nxt;
  logic        neg_a_r;
  digit_vec_t  dig_a_r;
  logic [63:0] qb;
  logic [63:0] rm;
  logic        fix;
  logic [63:0] quo;
  logic [3:0]  rem;
  digit_vec_t  dig_nxt;

  // First half of the divide by ten: shifts and adds build n * 0.8.
  always_comb begin
    qa_nxt = (mag_in >> 1) + (mag_in >> 2);
    qa_nxt = qa_nxt + (qa_nxt >> 4);
    qa_nxt = qa_nxt + (qa_nxt >> 8);
  end

  // Second half: the finished estimate of n / 10 falls short by at most one,
  // so one compare on the remainder corrects it.
  always_comb begin
    qb = qa_r + (qa_r >> 16);
    qb = qb + (qb >> 32);
    qb = qb >> 3;
    rm = mag_a_r - ((qb << 3) + (qb << 1));
    fix = (rm > 64'd9);
    quo = fix ? (qb + 64'd1) : qb;
    rem = fix ? 4'(rm - 64'd10) : 4'(rm);
    dig_nxt = dig_a_r;
    dig_nxt[idx] = rem;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= vld_in;
      vld_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_a_r <= mag_in;
      qa_r <= qa_nxt;
      neg_a_r <= neg_in;
      dig_a_r <= dig_in;
      mag_r <= quo;
      neg_r <= neg_a_r;
      dig_r <= dig_nxt;
    end
  end
endmodule

// File: rtl/core/signed_int_to_decimal_ascii.sv
// Channel | Direction | Payload
// in_     | sink      | value (64-bit signed)
// out_    | source    | char_out (8), last (1)
// Each of the twenty digits takes two register stages, forty in all; the
// serializer registers behind them offer the first character of a value.
// The serializer then emits one character per cycle while out_ is ready,
// 1 to 20 characters per value as its text needs, which sets throughput.
// The pipeline advances only when its tail is free, so a stall on out_ holds
// every stage. Reset is synchronous, active low; in_ is not ready during reset.
module signed_int_to_decimal_ascii (
  input logic clk,
  input logic rst_n,
  sitoa_in_if.sink in_ch,
  sitoa_out_if.source out_ch
);
  import sitoa_pkg::*;

  logic        vld [DIGITS+1];
  logic [63:0] mag [DIGITS+1];
  logic        neg [DIGITS+1];
  digit_vec_t  dig [DIGITS+1];
  logic        adv;
  logic [63:0] raw;

  // Serializer state.
  logic        busy_r;
  digit_vec_t  sdig_r;
  logic [4:0]  pos_r, pos_nxt;
  logic        minus_r, minus_nxt;
  logic [4:0]  top;

  assign adv = !busy_r || (out_ch.ready && pos_r == 5'd0 && !minus_r);
  assign in_ch.ready = adv && rst_n;
  assign raw = 64'(in_ch.value[VALUE_BITS-1:0]);
  assign vld[0] = in_ch.valid;
  assign neg[0] = raw[VALUE_BITS-1];
  assign mag[0] = neg[0] ? ((~raw + 64'd1) & VALUE_MASK) : raw;
  assign dig[0] = '0;

  for (genvar g = 0; g < DIGITS; g++) begin : g_stage
    sitoa_digit_stage u_st (
      .clk(clk), .rst_n(rst_n), .en(adv),
      .vld_in(vld[g]), .mag_in(mag[g]), .neg_in(neg[g]), .dig_in(dig[g]),
      .idx(5'(g)),
      .vld_r(vld[g+1]), .mag_r(mag[g+1]), .neg_r(neg[g+1]), .dig_r(dig[g+1])
    );
  end

  // Highest nonzero digit position (zero gives position 0).
  always_comb begin
    top = '0;
    for (int k = 1; k < DIGITS; k++) begin
      if (dig[DIGITS][k] != 4'd0) top = 5'(k);
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    minus_nxt = minus_r;
    if (adv) begin
      pos_nxt = top;
      minus_nxt = neg[DIGITS];
    end else if (out_ch.ready) begin
      if (minus_r) minus_nxt = 1'b0;
      else pos_nxt = pos_r - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (adv) begin
      busy_r <= vld[DIGITS];
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    minus_r <= minus_nxt;
    if (adv) sdig_r <= dig[DIGITS];
  end

  assign out_ch.valid = busy_r;
  assign out_ch.char_out = minus_r ? CHAR_MINUS : (CHAR_ZERO + {4'd0, sdig_r[pos_r]});
  assign out_ch.last = !minus_r && pos_r == 5'd0;
endmodule

// File: rtl/core/sitoa_checker.sv
module sitoa_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic [7:0] out_char,
  input logic out_last
);
  import sitoa_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last))
    else $error("output changed under stall");
  a_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char == CHAR_MINUS) ||
                  (out_char >= CHAR_ZERO && out_char <= CHAR_ZERO + 8'd9))
    else $error("bad character");
  a_minus_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_char == CHAR_MINUS |-> !out_last)
    else $error("minus marked last");
endmodule

bind signed_int_to_decimal_ascii sitoa_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_char(out_ch.char_out), .out_last(out_ch.last)
);
